// ===== hw/rtl/ack_pkg.sv =====
// ============================================================================
// ack_pkg
// Shared types and constants for the acknowledge-frame deframer.
// ============================================================================
package ack_pkg;

    // Default for the smallest frame that is dropped (frames of this
    // many bytes or more are discarded).
    localparam int MAX_FRAME_DEFAULT = 50;

    // Reset value of the acknowledge package id register.
    localparam logic [7:0] ACK_ID_RESET = 8'h07;

    // Bytes outside the length count: header, id and length; the checksum is counted in the length.
    localparam int FRAME_OVERHEAD = 9;

    // Byte positions within a frame.
    localparam int POS_PID    = 6;
    localparam int POS_LEN_HI = 7;
    localparam int POS_LEN_LO = 8;
    localparam int POS_CODE   = 9;
    localparam int POS_P1_HI  = 10;
    localparam int POS_P1_LO  = 11;
    localparam int POS_P2_HI  = 12;
    localparam int POS_P2_LO  = 13;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_CHECKSUM = 2'd1,
        STATUS_NOT_ACK  = 2'd2
    } status_t;

    // One received byte with its start-of-frame flag.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } item_t;

    // One frame result.
    typedef struct packed {
        status_t     frame_status;
        logic [7:0]  module_code;
        logic [15:0] param_one;
        logic [15:0] param_two;
    } result_t;

endpackage

// ===== hw/rtl/ack_in_stage.sv =====
// ============================================================================
// ack_in_stage
// Input register for received bytes; accepts a new word every cycle the
// downstream stage advances.
// ============================================================================
module ack_in_stage
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ack_pkg::item_t in_item,
    input  logic          advance,
    output logic          item_valid,
    output ack_pkg::item_t item
);

    logic           valid_reg;
    ack_pkg::item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== hw/rtl/ack_parser.sv =====
// ============================================================================
// ack_parser
// Frame state: byte position, length, running checksum, captured fields.
// Produces at most one result per byte, at the last byte of a frame.
// ============================================================================
module ack_parser
#(
    parameter int MAX_FRAME = ack_pkg::MAX_FRAME_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       ack_package_id,
    input  logic             item_valid,
    input  ack_pkg::item_t   item,
    input  logic             advance,
    output logic             res_valid,
    output ack_pkg::result_t res
);

    localparam int POS_W = $clog2(MAX_FRAME);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             dropping_reg, dropping_next;
    logic [7:0]       len_hi_reg, len_hi_next;
    logic [POS_W-1:0] total_reg, total_next;
    logic [15:0]      sum_reg, sum_next;
    logic [15:0]      window_reg, window_next;
    logic [7:0]       pid_reg, pid_next;
    logic [7:0]       code_reg, code_next;
    logic [15:0]      p1_reg, p1_next;
    logic [15:0]      p2_reg, p2_next;

    // Frame state as seen by this byte: a start flag clears everything.
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] total_cur;
    logic [8:0]       len_lo_total;
    logic             fire;
    logic             active;
    logic             drop;
    logic             frame_end;
    logic [7:0]       b;

    assign fire   = item_valid && advance;
    assign b      = item.rx_byte;
    assign active = item.frame_start || !dropping_reg;
    assign p      = item.frame_start ? '0 : pos_reg;

    // Low length byte plus the fixed overhead; the high byte must be zero.
    assign len_lo_total = {1'b0, b} + 9'(ack_pkg::FRAME_OVERHEAD);

    always_comb
    begin
        sum_next    = item.frame_start ? 16'd0 : sum_reg;
        window_next = item.frame_start ? 16'd0 : window_reg;
        pid_next    = item.frame_start ? 8'd0  : pid_reg;
        len_hi_next = item.frame_start ? 8'd0  : len_hi_reg;
        total_next  = item.frame_start ? '0    : total_reg;
        code_next   = item.frame_start ? 8'd0  : code_reg;
        p1_next     = item.frame_start ? 16'd0 : p1_reg;
        p2_next     = item.frame_start ? 16'd0 : p2_reg;
        drop        = 1'b0;

        // The byte two places back leaves the window and joins the sum.
        if (p >= POS_W'(ack_pkg::POS_LEN_LO))
        begin
            sum_next = sum_next + {8'd0, window_next[15:8]};
        end
        window_next = {window_next[7:0], b};

        case (p)
            POS_W'(ack_pkg::POS_PID):
            begin
                pid_next = b;
            end
            POS_W'(ack_pkg::POS_LEN_HI):
            begin
                len_hi_next = b;
            end
            POS_W'(ack_pkg::POS_LEN_LO):
            begin
                drop       = (len_hi_next != 8'd0) || (len_lo_total >= 9'(MAX_FRAME));
                total_next = len_lo_total[POS_W-1:0];
            end
            POS_W'(ack_pkg::POS_CODE):
            begin
                code_next = b;
            end
            POS_W'(ack_pkg::POS_P1_HI), POS_W'(ack_pkg::POS_P1_LO):
            begin
                p1_next = {p1_next[7:0], b};
            end
            POS_W'(ack_pkg::POS_P2_HI), POS_W'(ack_pkg::POS_P2_LO):
            begin
                p2_next = {p2_next[7:0], b};
            end
            default:
            begin
            end
        endcase

        total_cur = total_next;
        frame_end = !drop && (p >= POS_W'(ack_pkg::POS_LEN_LO))
                    && (({1'b0, p} + 1'b1) == {1'b0, total_cur});

        dropping_next = drop || frame_end;
        pos_next      = frame_end ? p : p + 1'b1;
    end

    always_comb
    begin
        res = '0;
        if (sum_next != window_next)
        begin
            res.frame_status = ack_pkg::STATUS_CHECKSUM;
        end
        else if (pid_next != ack_package_id)
        begin
            res.frame_status = ack_pkg::STATUS_NOT_ACK;
        end
        else
        begin
            res.frame_status = ack_pkg::STATUS_OK;
            res.module_code  = code_next;
            res.param_one    = p1_next;
            res.param_two    = p2_next;
        end
    end

    assign res_valid = fire && active && frame_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            dropping_reg <= 1'b1;
        end
        else if (fire && active)
        begin
            pos_reg      <= pos_next;
            dropping_reg <= dropping_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && active)
        begin
            sum_reg    <= sum_next;
            window_reg <= window_next;
            pid_reg    <= pid_next;
            len_hi_reg <= len_hi_next;
            total_reg  <= total_next;
            code_reg   <= code_next;
            p1_reg     <= p1_next;
            p2_reg     <= p2_next;
        end
    end

endmodule

// ===== hw/rtl/ack_out_stage.sv =====
// ============================================================================
// ack_out_stage
// Result register; holds a finished result until the sink takes it.
// ============================================================================
module ack_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  ack_pkg::result_t res,
    output logic             advance,
    output logic             out_valid,
    input  logic             out_ready,
    output ack_pkg::result_t out_res
);

    logic             valid_reg;
    ack_pkg::result_t res_reg;

    assign advance   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

// ===== hw/rtl/ack_frame_deframer_checksum_core.sv =====
// ============================================================================
// ack_frame_deframer_checksum_core
// Deframer for length-prefixed acknowledge frames with a 16-bit additive sum.
// ============================================================================
// Path: the last byte of a frame passes the input register, then the parser,
// which feeds its result word into the result register.
// Throughput: one byte word per cycle, sustained while the sink takes results;
// a result word the sink has not taken holds back the bytes behind it.
// Reset: rst_n clears the pipeline valids and puts the parser in its
// wait-for-frame-start state; the package id register returns to 0x07.
// ============================================================================
module ack_frame_deframer_checksum_core
#(
    parameter int MAX_FRAME = ack_pkg::MAX_FRAME_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration: acknowledge package id.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,

    // Received bytes.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] frame_start

    // Frame results.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] module_code, [23:8] param_one,
                                        // [39:24] param_two
    output logic [1:0]  m_axis_tuser    // [1:0] frame_status
);

    logic [7:0]       ack_id_reg;
    ack_pkg::item_t   in_item;
    ack_pkg::item_t   item;
    logic             item_valid;
    logic             advance;
    logic             res_valid;
    ack_pkg::result_t res;
    ack_pkg::result_t out_res;

    // The configuration register is always writable; the user must write it only
    // while the block is idle, which the block itself does not enforce.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_id_reg <= ack_pkg::ACK_ID_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            ack_id_reg <= cfg_data;
        end
    end

    assign in_item.rx_byte     = s_axis_tdata;
    assign in_item.frame_start = s_axis_tuser;

    // Input register. It takes a new word whenever the result register can
    // advance; a result that the sink has not yet taken holds back the byte
    // stream until it is taken.
    ack_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Frame parser: position counter, length check, running checksum and
    // field captures, all updated together for each byte.
    ack_parser
    #(
        .MAX_FRAME (MAX_FRAME)
    )
    u_parser
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ack_package_id (ack_id_reg),
        .item_valid     (item_valid),
        .item           (item),
        .advance        (advance),
        .res_valid      (res_valid),
        .res            (res)
    );

    // Result register toward the sink.
    ack_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {out_res.param_two, out_res.param_one, out_res.module_code};
    assign m_axis_tuser = out_res.frame_status;

endmodule
